>>> rtl/psvpe_pkg.sv
// ----------------------------------------------------------------------------
// Program stream video payload extract: shared package
// Item types, parse phases, result codes and the bundle type that the front
// end hands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package psvpe_pkg;

    localparam int MAX_RES = 4;

    typedef enum logic [4:0] {
        PH_SEARCH  = 5'd0,
        PH_PACK    = 5'd1,
        PH_PSTUFF  = 5'd2,
        PH_LEN_HI  = 5'd3,
        PH_LEN_LO  = 5'd4,
        PH_SKIP    = 5'd5,
        PH_PLEN_HI = 5'd6,
        PH_PLEN_LO = 5'd7,
        PH_FLAGS1  = 5'd8,
        PH_FLAGS2  = 5'd9,
        PH_HDRLEN  = 5'd10,
        PH_HOPT    = 5'd11,
        PH_HEXT    = 5'd12,
        PH_HPACK   = 5'd13,
        PH_HEXT2   = 5'd14,
        PH_HREST   = 5'd15,
        PH_PAYLOAD = 5'd16
    } phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ERROR   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_PACK_MARK = 3'd1;
    localparam logic [2:0] ERR_HDR_SHORT = 3'd2;
    localparam logic [2:0] ERR_LEN_SHORT = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [1:0] REG_PES_LOW    = 2'd0;
    localparam logic [1:0] REG_PES_HIGH   = 2'd1;
    localparam logic [1:0] REG_VIDEO_LOW  = 2'd2;
    localparam logic [1:0] REG_VIDEO_HIGH = 2'd3;

    localparam logic [7:0]  ID_END_CODE = 8'hB9;
    localparam logic [7:0]  ID_PACK     = 8'hBA;
    localparam logic [7:0]  ID_SYS_HDR  = 8'hBB;
    localparam logic [7:0]  ID_MAP      = 8'hBC;
    localparam logic [7:0]  ID_PRIV     = 8'hBD;
    localparam logic [23:0] PREFIX      = 24'h000001;
    localparam logic [23:0] NO_PREFIX   = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] payload_byte;
        logic [7:0] stream_id_out;
        logic       packet_start;
        logic [2:0] error_code;
        logic       last;
    } out_t;

    typedef struct packed {
        out_t [MAX_RES-1:0] items;
        logic [2:0]         cnt;
    } bundle_t;

    typedef struct packed {
        phase_t      phase;
        logic [23:0] rb;
        logic [7:0]  csid;
        logic [7:0]  fbc;
        logic [15:0] pbl;
        logic [7:0]  hdl;
        logic [7:0]  fl;
        logic [7:0]  ols;
        logic [1:0]  hc;
        logic [2:0]  err;
    } parse_st_t;

    typedef struct packed {
        logic       full;
        logic [1:0] fill;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/psvpe_front.sv
// ----------------------------------------------------------------------------
// Program stream video payload extract: front end
// Accepts stream bytes, runs the start code and header parser and builds the
// bundle of result items that each byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module psvpe_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire psvpe_pkg::in_t      in_item,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data,
    input  wire psvpe_pkg::q_status_t q_status,
    output logic                     push,
    output psvpe_pkg::bundle_t       push_bundle
);

    psvpe_pkg::parse_st_t st_reg, st_next;
    logic [7:0] pes_lo_reg, pes_hi_reg, vid_lo_reg, vid_hi_reg;
    logic       accept;

    function automatic psvpe_pkg::bundle_t add_item(input psvpe_pkg::bundle_t b_in,
                                                   input psvpe_pkg::out_t it);
        psvpe_pkg::bundle_t b;
        b = b_in;
        if (b.cnt < 3'(psvpe_pkg::MAX_RES)) begin
            b.items[b.cnt[1:0]] = it;
            b.cnt = b.cnt + 3'd1;
        end
        return b;
    endfunction

    function automatic psvpe_pkg::out_t mk_item(input logic [1:0] kind, input logic [7:0] byt,
                                               input logic [7:0] sid, input logic ps,
                                               input logic [2:0] ec);
        psvpe_pkg::out_t o;
        o.out_kind      = kind;
        o.payload_byte  = byt;
        o.stream_id_out = (kind == psvpe_pkg::KIND_END) ? 8'd0 : sid;
        o.packet_start  = ps;
        o.error_code    = ec;
        o.last          = 1'b0;
        return o;
    endfunction

    function automatic psvpe_pkg::parse_st_t enter_search(input psvpe_pkg::parse_st_t s_in);
        psvpe_pkg::parse_st_t s;
        s = s_in;
        s.phase = psvpe_pkg::PH_SEARCH;
        s.rb    = psvpe_pkg::NO_PREFIX;
        s.hc    = 2'd0;
        return s;
    endfunction

    function automatic psvpe_pkg::parse_st_t start_code(input psvpe_pkg::parse_st_t s_in,
                                                       input logic [7:0] id,
                                                       input logic [7:0] plo,
                                                       input logic [7:0] phi);
        psvpe_pkg::parse_st_t s;
        s = s_in;
        if (id >= psvpe_pkg::ID_PACK) s.csid = id;
        if (id == psvpe_pkg::ID_PACK) begin
            s.phase = psvpe_pkg::PH_PACK;
            s.fbc   = 8'd0;
        end else if (id == psvpe_pkg::ID_SYS_HDR || id == psvpe_pkg::ID_MAP) begin
            s.phase = psvpe_pkg::PH_LEN_HI;
        end else if (id >= plo && id <= phi) begin
            s.csid  = id;
            s.phase = psvpe_pkg::PH_PLEN_HI;
        end else if (id >= psvpe_pkg::ID_PRIV) begin
            s.phase = psvpe_pkg::PH_LEN_HI;
        end else begin
            s.phase = psvpe_pkg::PH_SEARCH;
        end
        return s;
    endfunction

    // Picks the next optional header field. At most two passes are needed,
    // since a multi-byte field always ends the search on the following pass.
    function automatic psvpe_pkg::parse_st_t hdr_next(input psvpe_pkg::parse_st_t s_in);
        psvpe_pkg::parse_st_t s;
        logic done;
        s = s_in;
        done = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (!done) begin
                if (s.fbc != 8'd0) begin
                    s.phase = psvpe_pkg::PH_HOPT;
                    done = 1'b1;
                end else if (s.fl[7]) begin
                    s.fl[7] = 1'b0;
                    s.phase = psvpe_pkg::PH_HEXT;
                    done = 1'b1;
                end else if (s.fl[6]) begin
                    s.fl[6] = 1'b0;
                    if (s.hdl < 8'd16) begin
                        s.err = psvpe_pkg::ERR_HDR_SHORT;
                        done = 1'b1;
                    end else begin
                        s.ols = s.ols + 8'd16;
                        s.fbc = 8'd16;
                    end
                end else if (s.fl[5]) begin
                    s.fl[5] = 1'b0;
                    if (s.hdl < 8'd1) s.err = psvpe_pkg::ERR_HDR_SHORT;
                    else begin
                        s.ols = s.ols + 8'd1;
                        s.phase = psvpe_pkg::PH_HPACK;
                    end
                    done = 1'b1;
                end else if (s.fl[4] || s.fl[3]) begin
                    if (s.fl[4]) s.fl[4] = 1'b0;
                    else s.fl[3] = 1'b0;
                    if (s.hdl < 8'd2) begin
                        s.err = psvpe_pkg::ERR_HDR_SHORT;
                        done = 1'b1;
                    end else begin
                        s.ols = s.ols + 8'd2;
                        s.fbc = 8'd2;
                    end
                end else if (s.fl[2]) begin
                    s.fl[2] = 1'b0;
                    if (s.hdl < 8'd1) s.err = psvpe_pkg::ERR_HDR_SHORT;
                    else begin
                        s.ols = s.ols + 8'd1;
                        s.phase = psvpe_pkg::PH_HEXT2;
                    end
                    done = 1'b1;
                end else begin
                    s.fl = 8'd0;
                    if (s.hdl != 8'd0) s.phase = psvpe_pkg::PH_HREST;
                    else begin
                        s.hc  = 2'd0;
                        s.fbc = 8'd1;
                        if (s.pbl == 16'd0) s = enter_search(s);
                        else s.phase = psvpe_pkg::PH_PAYLOAD;
                    end
                    done = 1'b1;
                end
            end
        end
        return s;
    endfunction

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        psvpe_pkg::parse_st_t s;
        psvpe_pkg::bundle_t   bnd;
        logic [7:0]  b;
        logic        eos;
        logic [23:0] prev;
        logic [7:0]  f;
        logic [7:0]  n;
        logic        vid;
        logic        ext;
        s    = st_reg;
        bnd  = '0;
        b    = in_item.in_byte;
        eos  = in_item.end_of_stream;
        prev = st_reg.rb;
        f    = 8'd0;
        n    = 8'd0;
        ext  = 1'b0;
        s.err = psvpe_pkg::ERR_NONE;
        s.rb  = {st_reg.rb[15:0], b};
        vid  = (s.csid >= vid_lo_reg) && (s.csid <= vid_hi_reg);

        case (st_reg.phase)
            psvpe_pkg::PH_SEARCH:
            begin
                if (prev == psvpe_pkg::PREFIX) s = start_code(s, b, pes_lo_reg, pes_hi_reg);
            end
            psvpe_pkg::PH_PACK:
            begin
                if (s.fbc == 8'd0 && b[7:6] != 2'b01) s.err = psvpe_pkg::ERR_PACK_MARK;
                else if (s.fbc >= 8'd9) begin
                    s.fbc = {5'd0, b[2:0]};
                    if (s.fbc != 8'd0) s.phase = psvpe_pkg::PH_PSTUFF;
                    else s = enter_search(s);
                end else s.fbc = s.fbc + 8'd1;
            end
            psvpe_pkg::PH_PSTUFF:
            begin
                if (s.fbc != 8'd0) s.fbc = s.fbc - 8'd1;
                if (s.fbc == 8'd0) s = enter_search(s);
            end
            psvpe_pkg::PH_LEN_HI, psvpe_pkg::PH_PLEN_HI:
            begin
                s.pbl = {b, 8'd0};
                s.phase = (st_reg.phase == psvpe_pkg::PH_LEN_HI) ? psvpe_pkg::PH_LEN_LO
                                                                  : psvpe_pkg::PH_PLEN_LO;
            end
            psvpe_pkg::PH_LEN_LO:
            begin
                s.pbl = s.pbl | {8'd0, b};
                if (s.pbl != 16'd0) s.phase = psvpe_pkg::PH_SKIP;
                else s = enter_search(s);
            end
            psvpe_pkg::PH_SKIP:
            begin
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                if (s.pbl == 16'd0) s = enter_search(s);
            end
            psvpe_pkg::PH_PLEN_LO:
            begin
                s.pbl = s.pbl | {8'd0, b};
                if (s.pbl < 16'd3) s.err = psvpe_pkg::ERR_LEN_SHORT;
                else s.phase = psvpe_pkg::PH_FLAGS1;
            end
            psvpe_pkg::PH_FLAGS1:
            begin
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                s.phase = psvpe_pkg::PH_FLAGS2;
            end
            psvpe_pkg::PH_FLAGS2:
            begin
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                s.fl = b;
                s.phase = psvpe_pkg::PH_HDRLEN;
            end
            psvpe_pkg::PH_HDRLEN:
            begin
                ext = s.fl[0];
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                if (s.pbl < {8'd0, b}) s.err = psvpe_pkg::ERR_LEN_SHORT;
                else begin
                    if (s.fl[7:6] == 2'b10) f = f + 8'd5;
                    if (s.fl[7:6] == 2'b11) f = f + 8'd10;
                    if (s.fl[5]) f = f + 8'd6;
                    if (s.fl[4]) f = f + 8'd3;
                    if (s.fl[3]) f = f + 8'd1;
                    if (s.fl[2]) f = f + 8'd1;
                    if (s.fl[1]) f = f + 8'd2;
                    f = f + {7'd0, ext};
                    if (f > b) s.err = psvpe_pkg::ERR_HDR_SHORT;
                    else begin
                        s.hdl = b;
                        s.ols = f;
                        s.fbc = f - {7'd0, ext};
                        s.fl  = ext ? 8'h80 : 8'h00;
                        s = hdr_next(s);
                    end
                end
            end
            psvpe_pkg::PH_HOPT, psvpe_pkg::PH_HEXT, psvpe_pkg::PH_HPACK,
            psvpe_pkg::PH_HEXT2, psvpe_pkg::PH_HREST:
            begin
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                if (s.hdl != 8'd0) s.hdl = s.hdl - 8'd1;
                if (st_reg.phase == psvpe_pkg::PH_HOPT) begin
                    if (s.fbc != 8'd0) s.fbc = s.fbc - 8'd1;
                    if (s.fbc == 8'd0) s = hdr_next(s);
                end else if (st_reg.phase == psvpe_pkg::PH_HEXT) begin
                    // PES extension flags move to the
                    // positions that the field walk expects.
                    s.fl = {1'b0, b[7:4], b[0], 2'b00};
                    s = hdr_next(s);
                end else if (st_reg.phase == psvpe_pkg::PH_HREST) begin
                    if (s.hdl == 8'd0) begin
                        s.hc  = 2'd0;
                        s.fbc = 8'd1;
                        if (s.pbl == 16'd0) s = enter_search(s);
                        else s.phase = psvpe_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n = (st_reg.phase == psvpe_pkg::PH_HPACK) ? b : {1'b0, b[6:0]};
                    if (n > s.hdl) s.err = psvpe_pkg::ERR_HDR_SHORT;
                    else begin
                        s.ols = s.ols + n;
                        s.fbc = n;
                        s = hdr_next(s);
                    end
                end
            end
            psvpe_pkg::PH_PAYLOAD:
            begin
                if (s.pbl != 16'd0) s.pbl = s.pbl - 16'd1;
                if (s.hc == 2'd3) begin
                    if (b >= psvpe_pkg::ID_END_CODE) begin
                        s.hc = 2'd0;
                        s = start_code(s, b, pes_lo_reg, pes_hi_reg);
                    end else if (eos) s.hc = 2'd0;
                    else begin
                        for (int i = 0; i < 3; i++) begin
                            if (vid) begin
                                bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD,
                                    (i == 2) ? 8'd1 : 8'd0, s.csid, s.fbc[0],
                                    psvpe_pkg::ERR_NONE));
                                s.fbc = 8'd0;
                            end
                        end
                        s.hc = 2'd0;
                        if (vid) begin
                            bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD, b, s.csid,
                                s.fbc[0], psvpe_pkg::ERR_NONE));
                            s.fbc = 8'd0;
                        end
                    end
                end else if (b == 8'd0 && s.hc < 2'd2) begin
                    s.hc = s.hc + 2'd1;
                end else if (b == 8'd0) begin
                    if (vid) begin
                        bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD, 8'd0, s.csid,
                            s.fbc[0], psvpe_pkg::ERR_NONE));
                        s.fbc = 8'd0;
                    end
                end else if (b == 8'd1 && s.hc == 2'd2) begin
                    s.hc = 2'd3;
                end else begin
                    for (int i = 0; i < 2; i++) begin
                        if (vid && 2'(i) < s.hc) begin
                            bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD, 8'd0,
                                s.csid, s.fbc[0], psvpe_pkg::ERR_NONE));
                            s.fbc = 8'd0;
                        end
                    end
                    s.hc = 2'd0;
                    if (vid) begin
                        bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD, b, s.csid,
                            s.fbc[0], psvpe_pkg::ERR_NONE));
                        s.fbc = 8'd0;
                    end
                end
                if (s.phase == psvpe_pkg::PH_PAYLOAD && s.pbl == 16'd0) begin
                    // Held zeros and a held prefix go out as data at packet end.
                    for (int i = 0; i < 3; i++) begin
                        if (vid && 2'(i) < s.hc) begin
                            bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD,
                                (i == 2) ? 8'd1 : 8'd0, s.csid, s.fbc[0],
                                psvpe_pkg::ERR_NONE));
                            s.fbc = 8'd0;
                        end
                    end
                    s = enter_search(s);
                end
            end
            default:
            begin
                s = enter_search(s);
            end
        endcase

        if (s.err != psvpe_pkg::ERR_NONE) begin
            bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_ERROR, 8'd0, s.csid, 1'b0, s.err));
            s = enter_search(s);
        end
        if (eos) begin
            if (s.phase == psvpe_pkg::PH_PAYLOAD) begin
                vid = (s.csid >= vid_lo_reg) && (s.csid <= vid_hi_reg);
                for (int i = 0; i < 3; i++) begin
                    if (vid && 2'(i) < s.hc) begin
                        bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_PAYLOAD,
                            (i == 2) ? 8'd1 : 8'd0, s.csid, s.fbc[0], psvpe_pkg::ERR_NONE));
                        s.fbc = 8'd0;
                    end
                end
            end else if (s.phase != psvpe_pkg::PH_SEARCH) begin
                bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_ERROR, 8'd0, s.csid, 1'b0,
                    psvpe_pkg::ERR_TRUNCATED));
            end
            bnd = add_item(bnd, mk_item(psvpe_pkg::KIND_END, 8'd0, s.csid, 1'b0,
                psvpe_pkg::ERR_NONE));
            s = '0;
            s.phase = psvpe_pkg::PH_SEARCH;
            s.rb = psvpe_pkg::NO_PREFIX;
        end
        if (bnd.cnt != 3'd0) bnd.items[2'(bnd.cnt - 3'd1)].last = 1'b1;
        s.err = psvpe_pkg::ERR_NONE;
        st_next = s;
        push_bundle = bnd;
        push = accept && (bnd.cnt != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg       <= '0;
            st_reg.phase <= psvpe_pkg::PH_SEARCH;
            st_reg.rb    <= psvpe_pkg::NO_PREFIX;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pes_lo_reg <= 8'hC0;
            pes_hi_reg <= 8'hEF;
            vid_lo_reg <= 8'hE0;
            vid_hi_reg <= 8'hEF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                psvpe_pkg::REG_PES_LOW:   pes_lo_reg <= cfg_data;
                psvpe_pkg::REG_PES_HIGH:  pes_hi_reg <= cfg_data;
                psvpe_pkg::REG_VIDEO_LOW: vid_lo_reg <= cfg_data;
                default:                  vid_hi_reg <= cfg_data;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/psvpe_back.sv
// ----------------------------------------------------------------------------
// Program stream video payload extract: back end
// A two-entry queue of result bundles and a serialiser that delivers the
// items of the head bundle one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module psvpe_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire psvpe_pkg::bundle_t   push_bundle,
    output psvpe_pkg::q_status_t      q_status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output psvpe_pkg::out_t           out_item
);

    psvpe_pkg::bundle_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;
    logic [1:0] idx_reg;
    logic       pop;
    psvpe_pkg::bundle_t head;

    assign head      = mem_reg[rd_ptr_reg];
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = head.items[idx_reg];
    assign pop       = out_valid && out_ready && ({1'b0, idx_reg} == head.cnt - 3'd1);
    assign q_status.full = (fill_reg == 2'd2);
    assign q_status.fill = fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop) fill_next = fill_reg + 2'd1;
        else if (pop && !push) fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= push_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            idx_reg    <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                idx_reg    <= 2'd0;
            end else if (out_valid && out_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/program_stream_video_payload_extract_unit.sv
// ----------------------------------------------------------------------------
// Program stream video payload extract unit
// Demultiplexes an MPEG-2 program stream byte by byte and delivers the
// payload bytes of video PES packets, error reports and end markers.
// ----------------------------------------------------------------------------
// Throughput: one stream byte per cycle while out_ready is high and each byte
// causes at most one result item; a byte that causes n items (up to four)
// holds the output for n handshakes of the one-item-per-handshake serialiser.
// A byte's results are registered in the queue as it is accepted.
// Reset: rst_n clears the parser to start code search, empties the result
// queue and restores the id range registers to C0..EF and E0..EF.
`default_nettype none

module program_stream_video_payload_extract_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire psvpe_pkg::in_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output psvpe_pkg::out_t      out_item,
    input  wire logic            cfg_wr_en,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [7:0]      cfg_data
);

    // The front end parses one byte per accepted item and pushes the bundle of
    // results into the queue; it stalls only when the queue holds two bundles.
    psvpe_pkg::q_status_t q_status;
    psvpe_pkg::bundle_t   push_bundle;
    logic                 push;

    psvpe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .push        (push),
        .push_bundle (push_bundle)
    );

    // The back end hands out the items of each bundle in order, one per
    // output handshake, independently of the input side.
    psvpe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .q_status    (q_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    // The input is refused exactly when the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (q_status.fill != 2'd2))
        else $error("input ready does not follow queue fill");

    // An end of stream marker always closes the results of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_kind == psvpe_pkg::KIND_END |-> out_item.last)
        else $error("end marker without last");

    // Payload items never carry an error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_kind == psvpe_pkg::KIND_PAYLOAD
        |-> out_item.error_code == psvpe_pkg::ERR_NONE)
        else $error("payload item with error code");

    // A push is only possible while the queue has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

endmodule

`default_nettype wire
